@@ design/sync_framed_packet_deframer_assert.svh @@
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define SFPD_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define SFPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ design/sfpd_pkg.sv @@
package sfpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 32;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHK
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_OVERSIZE = 2'd2
    } status_t;

endpackage

@@ design/sfpd_cfg_if.sv @@
interface sfpd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfpd_pkg::BYTE_W-1:0] sync_value;

    modport source (output valid, output sync_value, input ready);
    modport sink   (input valid, input sync_value, output ready);
endinterface

@@ design/sfpd_in_if.sv @@
interface sfpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfpd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/sfpd_out_if.sv @@
interface sfpd_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfpd_pkg::ID_W-1:0]      frame_id;
    logic [sfpd_pkg::BYTE_W-1:0]    frame_length;
    logic [sfpd_pkg::PAYLOAD_W-1:0] payload;
    logic [sfpd_pkg::STATUS_W-1:0]  frame_status;

    modport source (output valid, output frame_id, output frame_length,
                    output payload, output frame_status, input ready);
    modport sink   (input valid, input frame_id, input frame_length,
                    input payload, input frame_status, output ready);
endinterface

@@ design/sync_framed_packet_deframer.sv @@
// Byte-stream deframer: hunts for the sync byte (register sync_value, reset 0xAA), then
// collects ID_BYTES identifier bytes (least significant first), a length byte, up to
// MAX_PAYLOAD payload bytes and an XOR checksum byte, and returns one frame word on the
// checksum byte with status good, checksum mismatch, or oversized length. It takes one
// byte every cycle unless stalled by the output side. A byte is registered at the input
// and parsed by a single-stage state machine once the output register is free; at its
// end the frame word for a checksum byte is loaded into the output register, where it
// is valid and held until taken. Input ready drops only while the input register is
// full and the output register holds a word that is not taken this cycle.
// The sync register is always ready and should be written while the block is idle.
`include "sync_framed_packet_deframer_assert.svh"

module sync_framed_packet_deframer #(
    parameter int MAX_PAYLOAD = 8,
    parameter int ID_BYTES    = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    sfpd_cfg_if.sink       cfg,
    sfpd_in_if.sink        rx,
    sfpd_out_if.source     frame
);

    localparam int IdCntW  = $clog2(ID_BYTES + 1);
    localparam int PayCntW = $clog2(MAX_PAYLOAD + 1);
    localparam int BW      = sfpd_pkg::BYTE_W;

    // Control registers
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    sfpd_pkg::phase_t         phase_reg;
    sfpd_pkg::phase_t         phase_next;
    logic [IdCntW-1:0]        id_cnt_reg;
    logic [IdCntW-1:0]        id_cnt_next;
    logic [PayCntW-1:0]       pay_cnt_reg;
    logic [PayCntW-1:0]       pay_cnt_next;
    logic [BW-1:0]            sync_reg;

    // Data registers
    logic [BW-1:0]                  in_byte_reg;
    logic [sfpd_pkg::ID_W-1:0]      id_acc_reg;
    logic [sfpd_pkg::ID_W-1:0]      id_acc_next;
    logic [BW-1:0]                  length_reg;
    logic [BW-1:0]                  length_next;
    logic [sfpd_pkg::PAYLOAD_W-1:0] pay_reg;
    logic [sfpd_pkg::PAYLOAD_W-1:0] pay_next;
    logic [BW-1:0]                  xor_reg;
    logic [BW-1:0]                  xor_next;
    logic [sfpd_pkg::ID_W-1:0]      out_id_reg;
    logic [BW-1:0]                  out_len_reg;
    logic [sfpd_pkg::PAYLOAD_W-1:0] out_pay_reg;
    sfpd_pkg::status_t              out_status_reg;

    logic                 out_free;
    logic                 proc_go;
    logic                 emit;
    sfpd_pkg::status_t    status;
    logic                 len_in_range;
    logic                 pay_last;

    logic                 chk_go;
    logic                 at_sync;
    logic                 in_stall;
    logic                 in_data;
    logic                 pay_in_bound;

    assign out_free = !out_valid_reg || frame.ready;
    assign proc_go  = in_valid_reg && out_free;

    assign rx.ready  = !in_valid_reg || proc_go;
    assign cfg.ready = 1'b1;

    assign len_in_range = (in_byte_reg != '0) && (in_byte_reg <= BW'(MAX_PAYLOAD));
    assign pay_last     = ((BW'(pay_cnt_reg) + BW'(1)) >= length_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (proc_go)
        begin
            case (phase_reg)
                sfpd_pkg::PH_ID:
                begin
                    if (id_cnt_reg == IdCntW'(ID_BYTES - 1))
                        phase_next = sfpd_pkg::PH_LEN;
                end
                sfpd_pkg::PH_LEN:
                begin
                    if (len_in_range)
                        phase_next = sfpd_pkg::PH_DATA;
                    else
                        phase_next = sfpd_pkg::PH_CHK;
                end
                sfpd_pkg::PH_DATA:
                begin
                    if (pay_last)
                        phase_next = sfpd_pkg::PH_CHK;
                end
                sfpd_pkg::PH_CHK:
                begin
                    phase_next = sfpd_pkg::PH_SYNC;
                end
                default:
                begin
                    if (in_byte_reg == sync_reg)
                        phase_next = sfpd_pkg::PH_ID;
                    else
                        phase_next = sfpd_pkg::PH_SYNC;
                end
            endcase
        end
    end

    // Per-phase datapath updates and result decision
    always_comb
    begin
        id_cnt_next  = id_cnt_reg;
        id_acc_next  = id_acc_reg;
        length_next  = length_reg;
        pay_next     = pay_reg;
        pay_cnt_next = pay_cnt_reg;
        xor_next     = xor_reg;
        emit         = 1'b0;
        status       = sfpd_pkg::STATUS_GOOD;
        if (xor_reg != in_byte_reg)
            status = sfpd_pkg::STATUS_MISMATCH;
        else if (length_reg > BW'(MAX_PAYLOAD))
            status = sfpd_pkg::STATUS_OVERSIZE;
        if (proc_go)
        begin
            case (phase_reg)
                sfpd_pkg::PH_ID:
                begin
                    for (int k = 0; k < ID_BYTES; k++)
                    begin
                        if (id_cnt_reg == IdCntW'(k))
                            id_acc_next[BW*k +: BW] = id_acc_reg[BW*k +: BW] | in_byte_reg;
                    end
                    id_cnt_next = id_cnt_reg + IdCntW'(1);
                end
                sfpd_pkg::PH_LEN:
                begin
                    length_next  = in_byte_reg;
                    xor_next     = in_byte_reg;
                    pay_next     = '0;
                    pay_cnt_next = '0;
                end
                sfpd_pkg::PH_DATA:
                begin
                    for (int k = 0; k < MAX_PAYLOAD; k++)
                    begin
                        if (pay_cnt_reg == PayCntW'(k))
                            pay_next[BW*k +: BW] = pay_reg[BW*k +: BW] | in_byte_reg;
                    end
                    xor_next     = xor_reg ^ in_byte_reg;
                    pay_cnt_next = pay_cnt_reg + PayCntW'(1);
                end
                sfpd_pkg::PH_CHK:
                begin
                    emit = 1'b1;
                end
                default:
                begin
                    if (in_byte_reg == sync_reg)
                    begin
                        id_cnt_next = '0;
                        id_acc_next = '0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (proc_go)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (proc_go && emit)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= sfpd_pkg::PH_SYNC;
            id_cnt_reg    <= '0;
            pay_cnt_reg   <= '0;
            sync_reg      <= sfpd_pkg::SYNC_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            id_cnt_reg    <= id_cnt_next;
            pay_cnt_reg   <= pay_cnt_next;
            if (cfg.valid && cfg.ready)
                sync_reg <= cfg.sync_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        id_acc_reg <= id_acc_next;
        length_reg <= length_next;
        pay_reg    <= pay_next;
        xor_reg    <= xor_next;
        if (proc_go && emit)
        begin
            out_id_reg     <= id_acc_reg;
            out_len_reg    <= length_reg;
            out_pay_reg    <= pay_reg;
            out_status_reg <= status;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.frame_id     = out_id_reg;
    assign frame.frame_length = out_len_reg;
    assign frame.payload      = out_pay_reg;
    assign frame.frame_status = out_status_reg;

    assign chk_go       = proc_go && (phase_reg == sfpd_pkg::PH_CHK);
    assign at_sync      = (phase_reg == sfpd_pkg::PH_SYNC);
    assign in_stall     = in_valid_reg && !proc_go;
    assign in_data      = (phase_reg == sfpd_pkg::PH_DATA);
    assign pay_in_bound = (BW'(pay_cnt_reg) < length_reg) && (length_reg <= BW'(MAX_PAYLOAD));

    // A checksum byte always lands a word in the output register.
    `SFPD_ASSERT_NEXT(a_chk_emits, chk_go, out_valid_reg && at_sync, "checksum byte gave no word")
    // A parked input byte must not be lost or overwritten.
    `SFPD_ASSERT_NEXT(a_in_hold, in_stall, in_valid_reg && $stable(in_byte_reg), "input byte lost")
    // The payload count stays below the received length while collecting payload.
    `SFPD_ASSERT_NOW(a_pay_bound, in_data, pay_in_bound, "payload count out of range")
    // The parser only advances when the output side can absorb a word.
    `SFPD_ASSERT_NOW(a_no_overrun, proc_go && emit, !out_valid_reg || frame.ready, "word overrun")

endmodule
